### rtl/uap_pkg.sv
// Shared types and constants of the URI authority parser.
package uap_pkg;

   // Longest URI accepted; later bytes are dropped and flagged.
   localparam int MAX_URI_BYTES = 4096;
   localparam int POS_W         = $clog2(MAX_URI_BYTES + 1);

   // Field widths of the result.
   localparam int OFS_W  = 12;
   localparam int HLEN_W = 8;
   localparam int PLEN_W = 12;
   localparam int PORT_W = 16;

   // Host and port limits.
   localparam int LABEL_LIMIT   = 63;
   localparam int HOST_LIMIT    = 254;
   localparam int MAX_V6_LABEL  = 4;
   localparam int MAX_V6_HOST   = 39;
   localparam int MAX_V6_COLONS = 7;
   localparam int MIN_V6_COLONS = 2;
   localparam int MIN_HOST      = 2;
   localparam int MAX_PORT_DIGS = 5;
   localparam int MAX_PORT      = 65535;
   localparam int MIN_URI_BYTES = 7;
   localparam int HTTP_PORT     = 80;
   localparam int HTTPS_PORT    = 443;

   // Scheme match progress through "https".
   localparam logic [2:0] SCHEME_HTTP     = 3'd4;
   localparam logic [2:0] SCHEME_HTTPS    = 3'd5;
   localparam logic [2:0] SCHEME_MISMATCH = 3'd7;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_HTTP  = 2'd1;
   localparam logic [1:0] KIND_HTTPS = 2'd2;

   typedef enum logic [3:0] {
      PH_SCHEME = 4'd0,
      PH_SKIP   = 4'd1,
      PH_HSTART = 4'd2,
      PH_HOST   = 4'd3,
      PH_V6     = 4'd4,
      PH_V6END  = 4'd5,
      PH_PORT   = 4'd6,
      PH_PATH   = 4'd7,
      PH_DEAD   = 4'd8
   } phase_type;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_NO_COLON   = 4'd1,
      ERR_TOO_SHORT  = 4'd2,
      ERR_HOST_CHAR  = 4'd3,
      ERR_LABEL_LONG = 4'd4,
      ERR_HOST_LONG  = 4'd5,
      ERR_IPV6       = 4'd6,
      ERR_HOST_SHORT = 4'd7,
      ERR_BAD_PORT   = 4'd8,
      ERR_PORT_RANGE = 4'd9,
      ERR_INPUT_LONG = 4'd10
   } err_type;

   // Running state of the parse of one URI.
   typedef struct packed {
      phase_type          phase;
      logic [POS_W-1:0]   position;
      logic [2:0]         scheme_match;
      logic [6:0]         label_count;
      logic [8:0]         host_count;
      logic [3:0]         colon_count;
      logic [16:0]        port_value;
      logic [2:0]         port_digits;
      err_type            first_error;
      logic               ipv6_flag;
      logic [POS_W-1:0]   host_start;
      logic [POS_W-1:0]   path_start;
      logic [PLEN_W-1:0]  path_count;
      logic               hash_seen;
      logic               too_long;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase: PH_SCHEME,
      first_error: ERR_NONE,
      default: '0
   };

endpackage

### rtl/uap_req_if.sv
// Request channel of the URI authority parser: one URI byte per request.
interface uap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] uri_byte;
   logic       last_byte;

   modport source (output valid, output uri_byte, output last_byte, input ready);
   modport sink   (input valid, input uri_byte, input last_byte, output ready);
endinterface

### rtl/uap_rsp_if.sv
// Response channel of the URI authority parser: one verdict per URI.
interface uap_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       valid_res;
   logic [3:0]                 error_code;
   logic [1:0]                 scheme_kind;
   logic [uap_pkg::PORT_W-1:0] port;
   logic                       host_is_ipv6;
   logic [uap_pkg::OFS_W-1:0]  host_offset;
   logic [uap_pkg::HLEN_W-1:0] host_length;
   logic [uap_pkg::OFS_W-1:0]  path_offset;
   logic [uap_pkg::PLEN_W-1:0] path_length;

   modport source (output valid, output valid_res, output error_code, output scheme_kind,
                   output port, output host_is_ipv6, output host_offset,
                   output host_length, output path_offset, output path_length,
                   input ready);
   modport sink   (input valid, input valid_res, input error_code, input scheme_kind,
                   input port, input host_is_ipv6, input host_offset,
                   input host_length, input path_offset, input path_length,
                   output ready);
endinterface

### rtl/uap_step.sv
// Next-state logic of the parser for one URI byte.
module uap_step (
   input  uap_pkg::parse_state_type cur,
   input  logic [7:0]               uri_byte,
   output uap_pkg::parse_state_type nxt
);
   import uap_pkg::*;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
   endfunction

   function automatic logic is_hex(logic [7:0] b);
      return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
   endfunction

   // Character of "https" expected at a given match position.
   function automatic logic [7:0] https_char(logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:          c = "h";
         3'd1, 3'd2:    c = "t";
         3'd3:          c = "p";
         default:       c = "s";
      endcase
      return c;
   endfunction

   // Only the first fault is kept; the parse then stops.
   function automatic parse_state_type do_fail(parse_state_type s, err_type code);
      if (s.first_error == ERR_NONE) begin
         s.first_error = code;
      end
      s.phase = PH_DEAD;
      return s;
   endfunction

   // Path bytes are counted up to '#', saturating at the field width.
   function automatic parse_state_type path_byte(parse_state_type s, logic [7:0] b);
      if (!s.hash_seen) begin
         if (b == "#") begin
            s.hash_seen = 1'b1;
         end else if (s.path_count != '1) begin
            s.path_count = s.path_count + 1'b1;
         end
      end
      return s;
   endfunction

   function automatic parse_state_type path_begin(parse_state_type s,
                                                  logic [POS_W-1:0] p, logic [7:0] b);
      s.phase      = PH_PATH;
      s.path_start = p;
      s.path_count = '0;
      s.hash_seen  = 1'b0;
      return path_byte(s, b);
   endfunction

   function automatic logic port_in_range(parse_state_type s);
      return !((s.port_digits != '0) && (s.port_value > 17'(MAX_PORT)));
   endfunction

   // One byte of a host name.
   function automatic parse_state_type host_byte(parse_state_type s,
                                                 logic [POS_W-1:0] p, logic [7:0] b);
      if ((b == "/") || (b == ":")) begin
         if (s.host_count < 9'(MIN_HOST)) begin
            return do_fail(s, ERR_HOST_SHORT);
         end
         if (b == ":") begin
            s.phase = PH_PORT;
         end else begin
            s = path_begin(s, p, b);
         end
         return s;
      end
      if (is_alpha(b) || is_digit(b) || (b == "-")) begin
         s.label_count = s.label_count + 1'b1;
         s.host_count  = s.host_count + 1'b1;
      end else if (b == ".") begin
         s.label_count = '0;
         s.host_count  = s.host_count + 1'b1;
      end else begin
         return do_fail(s, ERR_HOST_CHAR);
      end
      if (s.label_count > 7'(LABEL_LIMIT)) begin
         s = do_fail(s, ERR_LABEL_LONG);
      end else if (s.host_count > 9'(HOST_LIMIT)) begin
         s = do_fail(s, ERR_HOST_LONG);
      end
      return s;
   endfunction

   // One byte inside IPv6 brackets.
   function automatic parse_state_type v6_byte(parse_state_type s, logic [7:0] b);
      if (b == "/") begin
         return do_fail(s, ERR_IPV6);
      end
      if (b == ":") begin
         s.label_count = '0;
         s.host_count  = s.host_count + 1'b1;
         s.colon_count = s.colon_count + 1'b1;
         if (s.colon_count > 4'(MAX_V6_COLONS)) begin
            return do_fail(s, ERR_IPV6);
         end
      end else if (b == "]") begin
         if (s.colon_count < 4'(MIN_V6_COLONS)) begin
            s = do_fail(s, ERR_IPV6);
         end else begin
            s.phase = PH_V6END;
         end
         return s;
      end else if (is_hex(b)) begin
         s.label_count = s.label_count + 1'b1;
         s.host_count  = s.host_count + 1'b1;
      end else begin
         return do_fail(s, ERR_IPV6);
      end
      if ((s.label_count > 7'(MAX_V6_LABEL)) || (s.host_count > 9'(MAX_V6_HOST))) begin
         s = do_fail(s, ERR_IPV6);
      end
      return s;
   endfunction

   logic [7:0]       lower_byte;
   logic [POS_W-1:0] pos;

   assign pos        = cur.position;
   assign lower_byte = ((uri_byte >= "A") && (uri_byte <= "Z")) ? uri_byte + 8'd32 : uri_byte;

   // Advance the parse by one byte; bytes past the length limit are dropped.
   always_comb begin
      nxt = cur;
      if (cur.position >= POS_W'(MAX_URI_BYTES)) begin
         nxt.too_long = 1'b1;
      end else begin
         nxt.position = cur.position + 1'b1;
         unique case (cur.phase)
            PH_SCHEME: begin
               if (uri_byte == ":") begin
                  nxt.phase       = PH_SKIP;
                  nxt.label_count = '0;
               end else if ((cur.scheme_match < SCHEME_HTTPS) &&
                            (lower_byte == https_char(cur.scheme_match))) begin
                  nxt.scheme_match = cur.scheme_match + 1'b1;
               end else begin
                  nxt.scheme_match = SCHEME_MISMATCH;
               end
            end
            PH_SKIP: begin
               nxt.label_count = cur.label_count + 1'b1;
               if (nxt.label_count >= 7'd2) begin
                  nxt.label_count = '0;
                  nxt.phase       = PH_HSTART;
               end
            end
            PH_HSTART: begin
               if (uri_byte == "[") begin
                  nxt.ipv6_flag  = 1'b1;
                  nxt.host_start = pos + 1'b1;
                  nxt.phase      = PH_V6;
               end else if (uri_byte == "-") begin
                  nxt = do_fail(cur, ERR_HOST_CHAR);
                  nxt.position = cur.position + 1'b1;
               end else begin
                  nxt.host_start = pos;
                  nxt.phase      = PH_HOST;
                  nxt = host_byte(nxt, pos, uri_byte);
               end
            end
            PH_HOST: begin
               nxt = host_byte(nxt, pos, uri_byte);
            end
            PH_V6: begin
               nxt = v6_byte(nxt, uri_byte);
            end
            PH_V6END: begin
               if (uri_byte == ":") begin
                  nxt.phase = PH_PORT;
               end else begin
                  nxt = path_begin(nxt, pos, uri_byte);
               end
            end
            PH_PORT: begin
               if (uri_byte == "/") begin
                  if (!port_in_range(cur)) begin
                     nxt = do_fail(nxt, ERR_PORT_RANGE);
                  end else begin
                     nxt = path_begin(nxt, pos, uri_byte);
                  end
               end else if (is_digit(uri_byte)) begin
                  nxt.port_digits = cur.port_digits + 1'b1;
                  if (nxt.port_digits > 3'(MAX_PORT_DIGS)) begin
                     nxt = do_fail(nxt, ERR_BAD_PORT);
                  end else begin
                     // Times ten as two shifted copies, plus the digit.
                     nxt.port_value = {cur.port_value[13:0], 3'b000} +
                                      {cur.port_value[15:0], 1'b0} +
                                      {13'd0, uri_byte[3:0]};
                  end
               end else begin
                  nxt = do_fail(nxt, ERR_BAD_PORT);
               end
            end
            PH_PATH: begin
               nxt = path_byte(nxt, uri_byte);
            end
            default: begin
               nxt = cur;
               nxt.position = cur.position + 1'b1;
            end
         endcase
      end
   end

endmodule

### rtl/uri_authority_parser_unit.sv
// URI authority parser: consumes a URI byte by byte and issues one verdict per URI.
//
// Each request carries one URI byte; the byte flagged last_byte closes the URI and
// produces exactly one response holding the verdict, the scheme kind, the port (80 or
// 443 by default for http or https), and the host and path offsets and lengths. Bytes
// are taken at one per cycle with no gaps between URIs: a request enters an input
// register; when the held byte advances, the parse state is updated and, on a last
// byte, the verdict is loaded into the response register, which presents it until
// it is taken. A waiting verdict holds back only a last byte, and the bytes behind
// it wait in turn; other bytes keep flowing. Bytes beyond 4096 in one URI are
// dropped and the URI is rejected as too long. A rejected URI reports its error
// code with all other fields zero.
module uri_authority_parser_unit (
   input  logic           clock,
   input  logic           reset,
   uap_req_if.sink        req_bus,
   uap_rsp_if.source      rsp_bus
);
   import uap_pkg::*;

   typedef struct packed {
      logic              valid_res;
      err_type           error_code;
      logic [1:0]        scheme_kind;
      logic [PORT_W-1:0] port;
      logic              host_is_ipv6;
      logic [OFS_W-1:0]  host_offset;
      logic [HLEN_W-1:0] host_length;
      logic [OFS_W-1:0]  path_offset;
      logic [PLEN_W-1:0] path_length;
   } verdict_type;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   verdict_type     verdict_ff;
   verdict_type     verdict_in;
   logic            advance;
   logic            req_take;
   err_type         err_sel;
   logic [1:0]      kind;

   // The held byte advances unless it closes a URI while a verdict is still waiting.
   assign advance         = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !in_valid_ff || advance;
   assign req_take        = req_bus.valid && req_bus.ready;

   uap_step u_step (
      .cur      (state_ff),
      .uri_byte (in_byte_ff),
      .nxt      (state_in)
   );

   // Final checks on the state after the last byte, in priority order.
   always_comb begin
      err_sel = ERR_NONE;
      if (state_in.too_long) begin
         err_sel = ERR_INPUT_LONG;
      end else if (state_in.phase == PH_SCHEME) begin
         err_sel = ERR_NO_COLON;
      end else if (state_in.position < POS_W'(MIN_URI_BYTES)) begin
         err_sel = ERR_TOO_SHORT;
      end else if (state_in.first_error != ERR_NONE) begin
         err_sel = state_in.first_error;
      end else begin
         unique case (state_in.phase)
            PH_SKIP, PH_HSTART: err_sel = ERR_HOST_SHORT;
            PH_HOST: begin
               if (state_in.host_count < 9'(MIN_HOST)) begin
                  err_sel = ERR_HOST_SHORT;
               end
            end
            PH_V6: err_sel = ERR_IPV6;
            PH_PORT: begin
               if ((state_in.port_digits != '0) &&
                   (state_in.port_value > 17'(MAX_PORT))) begin
                  err_sel = ERR_PORT_RANGE;
               end
            end
            default: err_sel = ERR_NONE;
         endcase
      end
   end

   // Assemble the response fields; a rejected URI carries only its error code.
   always_comb begin
      if (state_in.scheme_match == SCHEME_HTTP) begin
         kind = KIND_HTTP;
      end else if (state_in.scheme_match == SCHEME_HTTPS) begin
         kind = KIND_HTTPS;
      end else begin
         kind = KIND_OTHER;
      end
      verdict_in = '{error_code: err_sel, default: '0};
      if (err_sel == ERR_NONE) begin
         verdict_in.valid_res    = 1'b1;
         verdict_in.scheme_kind  = kind;
         verdict_in.port         = state_in.port_value[PORT_W-1:0];
         if (state_in.port_value == '0) begin
            if (kind == KIND_HTTP) begin
               verdict_in.port = PORT_W'(HTTP_PORT);
            end else if (kind == KIND_HTTPS) begin
               verdict_in.port = PORT_W'(HTTPS_PORT);
            end
         end
         verdict_in.host_is_ipv6 = state_in.ipv6_flag;
         verdict_in.host_offset  = state_in.host_start[OFS_W-1:0];
         verdict_in.host_length  = state_in.host_count[HLEN_W-1:0];
         if (state_in.phase == PH_PATH) begin
            verdict_in.path_offset = state_in.path_start[OFS_W-1:0];
            verdict_in.path_length = state_in.path_count;
         end else begin
            verdict_in.path_offset = state_in.position[OFS_W-1:0];
            verdict_in.path_length = '0;
         end
      end
   end

   // Input register, parse state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= in_last_ff ? STATE_RESET : state_in;
         end
         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         in_byte_ff <= req_bus.uri_byte;
         in_last_ff <= req_bus.last_byte;
      end
      if (advance && in_last_ff) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.valid_res    = verdict_ff.valid_res;
   assign rsp_bus.error_code   = verdict_ff.error_code;
   assign rsp_bus.scheme_kind  = verdict_ff.scheme_kind;
   assign rsp_bus.port         = verdict_ff.port;
   assign rsp_bus.host_is_ipv6 = verdict_ff.host_is_ipv6;
   assign rsp_bus.host_offset  = verdict_ff.host_offset;
   assign rsp_bus.host_length  = verdict_ff.host_length;
   assign rsp_bus.path_offset  = verdict_ff.path_offset;
   assign rsp_bus.path_length  = verdict_ff.path_length;

`ifndef SYNTHESIS
   // The parse state is back at its reset value after every verdict.
   a_reset_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (state_ff == STATE_RESET))
      else $error("parse state not cleared after verdict");

   // A closing byte always leaves a pending verdict behind it.
   a_verdict_issued: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("verdict lost");

   // A held byte that cannot advance is neither dropped nor overwritten.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("stalled input byte changed");

   // The byte position never runs past the length limit.
   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.position <= POS_W'(MAX_URI_BYTES))
      else $error("byte position out of range");
`endif

endmodule
